/* rtl/ssa_pkg.sv */
// Shared types and constants for the server selection arbiter.
// Holds the item layouts, status and action codes and the register layout.
// No dependencies.
package ssa_pkg;

	localparam int WEIGHT_W = 8;
	localparam int RUN_W    = 8;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [RUN_W-1:0] RUN_MAX           = 8'd255;
	localparam logic [7:0]       MAX_RETRIES_RESET = 8'd3;

	localparam logic MODE_WRR = 1'b0;
	localparam logic MODE_LC  = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_MODE        = 1'b0;
	localparam logic REG_MAX_RETRIES = 1'b1;

	typedef enum logic [1:0] {
		ACT_ADD      = 2'd0,
		ACT_DISPATCH = 2'd1,
		ACT_OUTCOME  = 2'd2,
		ACT_HEALTH   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_DISPATCHED = 3'd1,
		ST_REJECTED   = 3'd2,
		ST_FORWARD    = 3'd3,
		ST_RETRY      = 3'd4,
		ST_GIVE_UP    = 3'd5,
		ST_FULL       = 3'd6
	} status_t;

	typedef struct packed {
		action_t             action;
		logic [WEIGHT_W-1:0] weight;
		logic                is_retry;
		logic [3:0]          server_id;
		logic                succeeded;
		logic [7:0]          attempt;
	} in_item_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] server_index;
	} out_item_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] max_retries;
	} cfg_regs_t;

endpackage

/* rtl/ssa_stream_if.sv */
// Valid/ready item channel used for commands and results.
// The payload type is set per instance; depends on nothing else.
interface ssa_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/ssa_cfg.sv */
// APB-style register file: selection mode and retry limit.
// Depends on ssa_pkg.
module ssa_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssa_pkg::ADDR_W-1:0] paddr,
	input  logic [ssa_pkg::DATA_W-1:0] pwdata,
	output logic [ssa_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output ssa_pkg::cfg_regs_t        regs
);
	import ssa_pkg::*;

	logic      wr_en;
	cfg_regs_t regs_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mode        <= MODE_WRR;
			regs_q.max_retries <= MAX_RETRIES_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MODE:        regs_q.mode        <= pwdata[0];
				REG_MAX_RETRIES: regs_q.max_retries <= pwdata[7:0];
				default:         regs_q.mode        <= regs_q.mode;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE:        prdata = DATA_W'(regs_q.mode);
			REG_MAX_RETRIES: prdata = DATA_W'(regs_q.max_retries);
			default:         prdata = '0;
		endcase
	end

	assign regs = regs_q;

endmodule

/* rtl/ssa_seq.sv */
// Sequencer and server table: read-modify-write on one entry memory,
// table scans for least connections and round-robin search.
// Depends on ssa_pkg and ssa_stream_if.
module ssa_seq #(
	parameter int MAX_SERVERS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ssa_pkg::cfg_regs_t regs,
	ssa_stream_if.sink         cmd,
	ssa_stream_if.source       rsp
);
	import ssa_pkg::*;

	localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W = $clog2(MAX_SERVERS + 1);
	localparam int CMP_W = CNT_W + IDX_W + 4;
	localparam int ENT_W = WEIGHT_W + COUNT_BITS + 1;
	localparam logic [COUNT_BITS-1:0] ONG_MAX  = '1;
	localparam logic [CNT_W-1:0]      CNT_FULL = CNT_W'(MAX_SERVERS);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_MODIFY = 4'b0010,
		S_SCAN   = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	// entry layout: {weight, ongoing, down}
	logic [ENT_W-1:0] entry_mem [MAX_SERVERS];
	logic [ENT_W-1:0] rd_q;

	logic             mem_we;
	logic             mem_re;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_raddr;
	logic [ENT_W-1:0] mem_wdata;

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [CNT_W-1:0]      active_q, active_d;
	logic [IDX_W-1:0]      cur_q, cur_d;
	logic [RUN_W-1:0]      run_q, run_d;
	in_item_t              item_q, item_d;
	logic [IDX_W-1:0]      target_q, target_d;
	logic [IDX_W-1:0]      scan_addr_q, scan_addr_d;
	logic [CNT_W-1:0]      scan_left_q, scan_left_d;
	logic                  pend_s1, pend_d;
	logic [IDX_W-1:0]      pend_idx_s1, pend_idx_d;
	logic [IDX_W-1:0]      best_idx_q, best_idx_d;
	logic [COUNT_BITS-1:0] best_ong_q, best_ong_d;
	logic [WEIGHT_W-1:0]   best_w_q, best_w_d;
	logic                  best_dn_q, best_dn_d;
	out_item_t             res_q, res_d;
	out_item_t             out_q, out_d;
	logic                  out_valid_q, out_valid_d;

	logic [WEIGHT_W-1:0]   rd_w;
	logic [COUNT_BITS-1:0] rd_ong;
	logic                  rd_dn;

	assign rd_w   = rd_q[ENT_W-1 -: WEIGHT_W];
	assign rd_ong = rd_q[COUNT_BITS:1];
	assign rd_dn  = rd_q[0];

	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] a,
			input logic [CNT_W-1:0] n);
		logic [CMP_W-1:0] s;
		s = CMP_W'(a) + CMP_W'(1);
		return (s >= CMP_W'(n)) ? '0 : s[IDX_W-1:0];
	endfunction

	function automatic logic [3:0] idx_field(input logic [IDX_W-1:0] a);
		logic [CMP_W-1:0] s;
		s = CMP_W'(a);
		return s[3:0];
	endfunction

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= entry_mem[mem_raddr];
		end
	end

	always_comb begin
		logic [CMP_W-1:0]      sid_ext;
		logic                  known;
		logic [IDX_W-1:0]      cur_n;
		logic [IDX_W-1:0]      first;
		logic [COUNT_BITS-1:0] new_ong;
		logic                  new_dn;
		logic [RUN_W-1:0]      run_next;
		logic                  take;
		logic [IDX_W-1:0]      bi;

		state_d     = state_q;
		count_d     = count_q;
		active_d    = active_q;
		cur_d       = cur_q;
		run_d       = run_q;
		item_d      = item_q;
		target_d    = target_q;
		scan_addr_d = scan_addr_q;
		scan_left_d = scan_left_q;
		pend_d      = pend_s1;
		pend_idx_d  = pend_idx_s1;
		best_idx_d  = best_idx_q;
		best_ong_d  = best_ong_q;
		best_w_d    = best_w_q;
		best_dn_d   = best_dn_q;
		res_d       = res_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !rsp.ready;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_waddr   = '0;
		mem_raddr   = '0;
		mem_wdata   = rd_q;

		sid_ext  = CMP_W'(cmd.payload.server_id);
		known    = sid_ext < CMP_W'(count_q);
		cur_n    = (CMP_W'(cur_q) >= CMP_W'(count_q)) ? '0 : cur_q;
		first    = wrap_next(target_q, count_q);
		new_ong  = rd_ong;
		new_dn   = rd_dn;
		run_next = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);
		take     = pend_s1 && !rd_dn && (best_dn_q || rd_ong < best_ong_q ||
			(rd_ong == best_ong_q && rd_w > best_w_q));
		bi       = take ? pend_idx_s1 : best_idx_q;

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					item_d = cmd.payload;
					res_d.server_index = '0;
					state_d = S_DONE;
					unique case (cmd.payload.action)
						ACT_ADD: begin
							if (count_q == CNT_FULL) begin
								res_d.status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[IDX_W-1:0];
								mem_wdata = {cmd.payload.weight, {COUNT_BITS{1'b0}}, 1'b0};
								count_d   = count_q + CNT_W'(1);
								active_d  = active_q + CNT_W'(1);
								res_d.status = ST_ACCEPTED;
								res_d.server_index = idx_field(count_q[IDX_W-1:0]);
							end
						end
						ACT_DISPATCH: begin
							if (count_q == '0 || (!cmd.payload.is_retry && active_q == '0)) begin
								res_d.status = ST_REJECTED;
							end else begin
								res_d.status = ST_DISPATCHED;
								cur_d = cur_n;
								if (regs.mode == MODE_WRR) begin
									mem_re    = 1'b1;
									mem_raddr = cur_n;
									target_d  = cur_n;
									res_d.server_index = idx_field(cur_n);
									state_d   = S_MODIFY;
								end else begin
									// walk the whole table from entry 0
									mem_re      = 1'b1;
									mem_raddr   = '0;
									scan_addr_d = wrap_next('0, count_q);
									scan_left_d = count_q - CNT_W'(1);
									pend_d      = 1'b1;
									pend_idx_d  = '0;
									best_idx_d  = '0;
									best_dn_d   = 1'b1;
									state_d     = S_SCAN;
								end
							end
						end
						ACT_OUTCOME: begin
							res_d.server_index = cmd.payload.server_id;
							if (cmd.payload.succeeded) begin
								res_d.status = ST_FORWARD;
							end else if (cmd.payload.attempt > regs.max_retries) begin
								res_d.status = ST_GIVE_UP;
							end else begin
								res_d.status = ST_RETRY;
							end
							if (known) begin
								mem_re    = 1'b1;
								mem_raddr = sid_ext[IDX_W-1:0];
								target_d  = sid_ext[IDX_W-1:0];
								state_d   = S_MODIFY;
							end
						end
						ACT_HEALTH: begin
							res_d.server_index = cmd.payload.server_id;
							res_d.status = ST_ACCEPTED;
							if (known) begin
								mem_re    = 1'b1;
								mem_raddr = sid_ext[IDX_W-1:0];
								target_d  = sid_ext[IDX_W-1:0];
								state_d   = S_MODIFY;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_MODIFY: begin
				mem_we    = 1'b1;
				mem_waddr = target_q;
				state_d   = S_DONE;
				unique case (item_q.action)
					ACT_DISPATCH: begin
						new_ong = (rd_ong == ONG_MAX) ? rd_ong : rd_ong + COUNT_BITS'(1);
						if (regs.mode == MODE_WRR) begin
							if (run_next < rd_w && !rd_dn) begin
								run_d = run_next;
							end else begin
								run_d = '0;
								if (active_q == '0) begin
									cur_d = '0;
								end else begin
									// search starts after the current server, ends on it
									mem_re      = 1'b1;
									mem_raddr   = first;
									scan_addr_d = wrap_next(first, count_q);
									scan_left_d = count_q - CNT_W'(1);
									pend_d      = 1'b1;
									pend_idx_d  = first;
									state_d     = S_SCAN;
								end
							end
						end
					end
					ACT_OUTCOME: begin
						new_ong = (rd_ong == '0) ? rd_ong : rd_ong - COUNT_BITS'(1);
						if (item_q.succeeded) begin
							new_dn = 1'b0;
						end else if (res_q.status == ST_RETRY) begin
							new_dn = 1'b1;
						end
					end
					ACT_HEALTH: begin
						new_dn = !item_q.succeeded;
					end
					default: new_dn = rd_dn;
				endcase
				mem_wdata = {rd_w, new_ong, new_dn};
				if (rd_dn && !new_dn) begin
					active_d = active_q + CNT_W'(1);
				end else if (!rd_dn && new_dn) begin
					active_d = active_q - CNT_W'(1);
				end
			end
			S_SCAN: begin
				if (scan_left_q != '0) begin
					mem_re      = 1'b1;
					mem_raddr   = scan_addr_q;
					scan_addr_d = wrap_next(scan_addr_q, count_q);
					scan_left_d = scan_left_q - CNT_W'(1);
					pend_d      = 1'b1;
					pend_idx_d  = scan_addr_q;
				end else begin
					pend_d = 1'b0;
				end
				if (regs.mode == MODE_WRR) begin
					if (pend_s1 && !rd_dn) begin
						cur_d   = pend_idx_s1;
						state_d = S_DONE;
					end else if (!pend_s1) begin
						cur_d   = '0;
						state_d = S_DONE;
					end
				end else begin
					if (take) begin
						best_idx_d = pend_idx_s1;
						best_ong_d = rd_ong;
						best_w_d   = rd_w;
						best_dn_d  = 1'b0;
					end
					if (scan_left_q == '0) begin
						// last entry seen: fetch the winner for its update
						mem_re    = 1'b1;
						mem_raddr = bi;
						target_d  = bi;
						res_d.server_index = idx_field(bi);
						state_d   = S_MODIFY;
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_d       = res_q;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			active_q    <= '0;
			cur_q       <= '0;
			run_q       <= '0;
			scan_left_q <= '0;
			pend_s1     <= 1'b0;
			best_dn_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			active_q    <= active_d;
			cur_q       <= cur_d;
			run_q       <= run_d;
			scan_left_q <= scan_left_d;
			pend_s1     <= pend_d;
			best_dn_q   <= best_dn_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q      <= item_d;
		target_q    <= target_d;
		scan_addr_q <= scan_addr_d;
		pend_idx_s1 <= pend_idx_d;
		best_idx_q  <= best_idx_d;
		best_ong_q  <= best_ong_d;
		best_w_q    <= best_w_d;
		res_q       <= res_d;
		out_q       <= out_d;
	end

	assign cmd.ready   = (state_q == S_IDLE);
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	a_active_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= count_q)
		else $error("active server count exceeds table size");

	a_cur_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cur_q) < CMP_W'(CNT_FULL))
		else $error("current server outside table");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_MODIFY || state_q == S_IDLE))
		else $error("table written outside add or modify");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("second item taken while one is in work");

	a_result_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || rsp.ready)) |=> (rsp.valid && cmd.ready))
		else $error("finished result not moved to output register");

endmodule

/* rtl/server_selection_arbiter.sv */
// Steps per item: an add, a rejected dispatch and an outcome or health check for an unknown
// server go straight to done; a known outcome or health check reads the entry and writes it
// back in modify. Round-robin dispatch modifies too and, when a run ends, scans for the next
// active server; least-connections dispatch scans all N servers, then modifies the winner.
// One item is in work at a time; the input reopens as its result is registered. Reset is
// asynchronous: control registers clear, table entries are written when added.
module server_selection_arbiter #(
	parameter int MAX_SERVERS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ssa_stream_if.sink                cmd,
	ssa_stream_if.source              rsp,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssa_pkg::ADDR_W-1:0] paddr,
	input  logic [ssa_pkg::DATA_W-1:0] pwdata,
	output logic [ssa_pkg::DATA_W-1:0] prdata,
	output logic                      pready
);
	import ssa_pkg::*;

	cfg_regs_t regs;

	ssa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regs    (regs)
	);

	ssa_seq #(
		.MAX_SERVERS (MAX_SERVERS),
		.COUNT_BITS  (COUNT_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule
